@@ hdl/whn_pkg.sv @@
// Shared types, constants and constant tables of the wave heightfield normal generator.
`timescale 1ns / 1ps

package whn_pkg;

  localparam int TABLE_LEN = 256;
  localparam int QUARTER   = TABLE_LEN / 4;
  localparam int NUM_PTS   = 9;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_GRID_SIZE  = 3'd0;
  localparam logic [2:0] CFG_DEPTH_GAIN = 3'd1;
  localparam logic [2:0] CFG_RATE0      = 3'd2;
  localparam logic [2:0] CFG_RATE1      = 3'd3;
  localparam logic [2:0] CFG_RATE2      = 3'd4;
  localparam logic [2:0] CFG_RATE3      = 3'd5;

  localparam logic [8:0]  GRID_RST  = 9'd33;
  localparam logic [15:0] DEPTH_RST = 16'd4096;
  localparam logic [15:0] RATE0_RST = 16'd3187;
  localparam logic [15:0] RATE1_RST = 16'd3643;
  localparam logic [15:0] RATE2_RST = 16'd4280;
  localparam logic [15:0] RATE3_RST = 16'd5199;

  // Iteration counts of the square root and the divider
  localparam int SQRT_STEPS = 29;
  localparam int DIV_STEPS  = 16;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                             64'd72, 64'd110, 64'd156};

  typedef logic signed [15:0] wave_row_t [TABLE_LEN];
  typedef logic [8:0] step_lut_t [TABLE_LEN];

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic       capture;
    logic       clear_norm;
    logic       tick_en;
    logic [1:0] wave;
    logic       pt_valid;
    logic [3:0] pt;
    logic       vec_en;
    logic       sq_en;
    logic       sq_first;
    logic [1:0] sq_sel;
    logic       sqrt_load;
    logic       sqrt_step;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [1:0] comp;
    logic       load_out;
  } whn_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic is_tick;
    logic bad;
    logic sq_zero;
  } whn_sts_t;

  // Sine in Q30 by a folded Taylor series
  function automatic longint sine_q30(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    int          kk;
    int          quad;
    int          r;
    kk   = k & (TABLE_LEN - 1);
    quad = kk / QUARTER;
    r    = kk % QUARTER;
    if ((quad & 1) == 1) r = QUARTER - r;
    x    = (64'(r) * PI_Q30) / 128;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if ((n & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (quad >= 2) ? -sum : sum;
  endfunction

  function automatic logic signed [15:0] table_entry(longint amp, int k);
    longint v;
    longint mag;
    longint q;
    v   = amp * sine_q30(k);
    mag = (v < 0) ? -v : v;
    q   = (mag + 327680) / 655360;
    return 16'((v < 0) ? -q : q);
  endfunction

  function automatic wave_row_t build_wave(int w);
    wave_row_t t;
    for (int i = 0; i < TABLE_LEN; i++) begin
      unique case (w)
        0:       t[i] = table_entry(-9, 2 * i + QUARTER);
        1:       t[i] = table_entry(-8, 4 * i + QUARTER);
        2:       t[i] = table_entry(4, 3 * i);
        default: t[i] = table_entry(-4, 8 * i + QUARTER);
      endcase
    end
    return t;
  endfunction

  // Table step per grid size minus one; zero is never used but reads as full length
  function automatic step_lut_t build_step();
    step_lut_t t;
    int        q;
    for (int i = 0; i < TABLE_LEN; i++) begin
      q = TABLE_LEN;
      if (i != 0) begin
        q = 0;
        for (int j = 1; j <= TABLE_LEN; j++) begin
          if (j * i <= TABLE_LEN) q = j;
        end
      end
      t[i] = 9'(q);
    end
    return t;
  endfunction

  localparam wave_row_t WAVE_TBL0 = build_wave(0);
  localparam wave_row_t WAVE_TBL1 = build_wave(1);
  localparam wave_row_t WAVE_TBL2 = build_wave(2);
  localparam wave_row_t WAVE_TBL3 = build_wave(3);
  localparam step_lut_t STEP_LUT  = build_step();

endpackage

@@ hdl/whn_datapath.sv @@
// Datapath: configuration, phases, height pipeline, square root, divider and result words.
`timescale 1ns / 1ps

module whn_datapath
  import whn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                req_type_i,
  input  logic [7:0]          grid_x_i,
  input  logic [7:0]          grid_y_i,
  input  logic [15:0]         elapsed_time_i,
  input  whn_cmd_t            cmd_i,
  output whn_sts_t            sts_o,
  output logic signed [18:0]  height_o,
  output logic signed [15:0]  normal_x_o,
  output logic signed [15:0]  normal_y_o,
  output logic signed [15:0]  normal_z_o,
  output logic                bad_index_o
);

  logic [8:0]  grid_q;
  logic [15:0] depth_q;
  logic [15:0] rate_q [4];
  logic [23:0] phase_q [4];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q    <= GRID_RST;
      depth_q   <= DEPTH_RST;
      rate_q[0] <= RATE0_RST;
      rate_q[1] <= RATE1_RST;
      rate_q[2] <= RATE2_RST;
      rate_q[3] <= RATE3_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_SIZE:  grid_q    <= cfg_wdata_i[8:0];
        CFG_DEPTH_GAIN: depth_q   <= cfg_wdata_i;
        CFG_RATE0:      rate_q[0] <= cfg_wdata_i;
        CFG_RATE1:      rate_q[1] <= cfg_wdata_i;
        CFG_RATE2:      rate_q[2] <= cfg_wdata_i;
        CFG_RATE3:      rate_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Latch the request word
  logic        tick_q;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic [15:0] el_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tick_q <= req_type_i;
      x_q    <= grid_x_i;
      y_q    <= grid_y_i;
      el_q   <= elapsed_time_i;
    end
  end

  // Effective grid, neighbors and table step
  logic [8:0] g;
  logic [7:0] gm1;
  logic [7:0] step8;
  logic [7:0] half8;
  logic [8:0] step9;
  logic       bad;
  logic [7:0] px;
  logic [7:0] qx;
  logic [7:0] py;
  logic [7:0] qy;

  always_comb begin
    if (grid_q < 9'd2) g = 9'd2;
    else if (grid_q > 9'(TABLE_LEN)) g = 9'(TABLE_LEN);
    else g = grid_q;
    gm1   = 8'(g - 9'd1);
    step9 = STEP_LUT[gm1];
    step8 = step9[7:0];
    half8 = step9[8:1];
    bad   = ({1'b0, x_q} >= g) || ({1'b0, y_q} >= g);
    px    = (x_q == 8'd0) ? gm1 : 8'(x_q - 8'd1);
    qx    = (x_q == gm1) ? 8'd0 : 8'(x_q + 8'd1);
    py    = (y_q == 8'd0) ? gm1 : 8'(y_q - 8'd1);
    qy    = (y_q == gm1) ? 8'd0 : 8'(y_q + 8'd1);
  end

  // Advance one phase per tick cycle
  logic [31:0] tick_prod;
  assign tick_prod = rate_q[cmd_i.wave] * el_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) phase_q[i] <= '0;
    end else if (cmd_i.tick_en) begin
      phase_q[cmd_i.wave] <= phase_q[cmd_i.wave] + tick_prod[31:8];
    end
  end

  // Height stage one: point select, table indices and wave sum
  logic [7:0]  col;
  logic [7:0]  row;
  logic [15:0] cs_p;
  logic [15:0] rh_p;
  logic [15:0] ch_p;
  logic [15:0] rs_p;
  logic [7:0]  idx0;
  logic [7:0]  idx1;
  logic [7:0]  idx2;
  logic [7:0]  idx3;
  logic signed [17:0] wsum;

  always_comb begin
    unique case (cmd_i.pt)
      4'd0:    begin col = x_q; row = y_q; end
      4'd1:    begin col = qx;  row = qy;  end
      4'd2:    begin col = px;  row = py;  end
      4'd3:    begin col = x_q; row = qy;  end
      4'd4:    begin col = x_q; row = py;  end
      4'd5:    begin col = px;  row = qy;  end
      4'd6:    begin col = qx;  row = py;  end
      4'd7:    begin col = qx;  row = y_q; end
      default: begin col = px;  row = y_q; end
    endcase
    cs_p = col * step8;
    rh_p = row * half8;
    ch_p = col * half8;
    rs_p = row * step8;
    idx0 = phase_q[0][23:16] + cs_p[7:0] - rh_p[7:0];
    idx1 = phase_q[1][23:16] + ch_p[7:0] + rs_p[7:0];
    idx2 = phase_q[2][23:16] + cs_p[7:0];
    idx3 = phase_q[3][23:16] + rs_p[7:0];
    wsum = 18'(WAVE_TBL0[idx0]) + 18'(WAVE_TBL1[idx1])
         + 18'(WAVE_TBL2[idx2]) + 18'(WAVE_TBL3[idx3]);
  end

  logic signed [17:0] wsum_q;
  logic [3:0]         pt1_q;
  logic               v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= cmd_i.pt_valid;
  end

  always_ff @(posedge clk_i) begin
    wsum_q <= wsum;
    pt1_q  <= cmd_i.pt;
  end

  // Height stage two: scale by depth and round half away from zero
  logic signed [34:0] hprod;
  logic [34:0]        hmag;
  logic [34:0]        hrnd;
  logic signed [18:0] hval;
  logic signed [18:0] h_q [NUM_PTS];

  always_comb begin
    hprod = wsum_q * $signed({1'b0, depth_q});
    hmag  = hprod[34] ? 35'(-hprod) : 35'(hprod);
    hrnd  = (hmag + 35'd8192) >> 14;
    hval  = hprod[34] ? 19'(-hrnd) : 19'(hrnd);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) h_q[pt1_q] <= hval;
  end

  // Normal vector before scaling
  logic signed [20:0] vx_q;
  logic signed [20:0] vy_q;
  logic signed [20:0] vz_q;
  logic signed [20:0] f1;
  logic signed [20:0] f2;
  logic signed [20:0] f3;
  logic signed [20:0] f4;

  always_comb begin
    f1 = 21'(h_q[1]) - 21'(h_q[2]);
    f2 = 21'(h_q[3]) - 21'(h_q[4]);
    f3 = 21'(h_q[5]) - 21'(h_q[6]);
    f4 = 21'(h_q[7]) - 21'(h_q[8]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vec_en) begin
      vx_q <= f1 - f3 + f4;
      vz_q <= f1 + f2 + f3;
      vy_q <= 21'($signed({5'd0, depth_q})) - 21'($signed({1'b0, depth_q, 4'd0}));
    end
  end

  // Sum of squares, one component a cycle
  logic signed [20:0] sq_op;
  logic signed [41:0] sq_val;
  logic [41:0]        acc_q;

  always_comb begin
    unique case (cmd_i.sq_sel)
      2'd0:    sq_op = vx_q;
      2'd1:    sq_op = vy_q;
      default: sq_op = vz_q;
    endcase
    sq_val = sq_op * sq_op;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      acc_q <= (cmd_i.sq_first ? 42'd0 : acc_q) + 42'(sq_val);
    end
  end

  // Square root, two bits of the radicand a cycle
  logic [57:0] rv_q;
  logic [57:0] rr_q;
  logic [57:0] rbit_q;
  logic [57:0] rtrial;

  assign rtrial = rr_q + rbit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_load) begin
      rv_q   <= {acc_q, 16'd0};
      rr_q   <= '0;
      rbit_q <= 58'd1 << 56;
    end else if (cmd_i.sqrt_step) begin
      if (rv_q >= rtrial) begin
        rv_q <= rv_q - rtrial;
        rr_q <= (rr_q >> 1) + rbit_q;
      end else begin
        rr_q <= rr_q >> 1;
      end
      rbit_q <= rbit_q >> 2;
    end
  end

  // Restoring divider, one quotient bit a cycle
  logic signed [20:0] dc;
  logic [19:0]        dmag;
  logic [45:0]        rem_q;
  logic [45:0]        dsh_q;
  logic [15:0]        quo_q;
  logic               cneg_q;
  logic [15:0]        qclamp;
  logic signed [15:0] nres;

  always_comb begin
    unique case (cmd_i.comp)
      2'd0:    dc = vx_q;
      2'd1:    dc = vy_q;
      default: dc = vz_q;
    endcase
    dmag   = dc[20] ? 20'(-dc) : 20'(dc);
    qclamp = (quo_q > 16'd16384) ? 16'd16384 : quo_q;
    nres   = cneg_q ? $signed(qclamp) : $signed(16'(-qclamp));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= {4'd0, dmag, 22'd0} + 46'(rr_q[28:1]);
      dsh_q  <= {2'd0, rr_q[28:0], 15'd0};
      quo_q  <= '0;
      cneg_q <= dc[20];
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        quo_q <= {quo_q[14:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // Normal components, zero unless a division stores them
  logic signed [15:0] nx_q;
  logic signed [15:0] ny_q;
  logic signed [15:0] nz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_norm) begin
      nx_q <= '0;
      ny_q <= '0;
      nz_q <= '0;
    end else if (cmd_i.div_store) begin
      unique case (cmd_i.comp)
        2'd0:    nx_q <= nres;
        2'd1:    ny_q <= nres;
        default: nz_q <= nres;
      endcase
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      height_o    <= (tick_q || bad) ? 19'sd0 : h_q[0];
      normal_x_o  <= nx_q;
      normal_y_o  <= ny_q;
      normal_z_o  <= nz_q;
      bad_index_o <= bad && !tick_q;
    end
  end

  assign sts_o.is_tick = tick_q;
  assign sts_o.bad     = bad;
  assign sts_o.sq_zero = (acc_q == 42'd0);

endmodule

@@ hdl/whn_ctrl.sv @@
// Sequencer: steps the datapath through a tick or a vertex query and owns the handshakes.
`timescale 1ns / 1ps

module whn_ctrl
  import whn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  whn_sts_t sts_i,
  output whn_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_TICK, ST_HGT, ST_VEC, ST_SQ, ST_CHECK,
    ST_SQRT, ST_DIV, ST_FINISH
  } state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  logic [1:0] comp_q;
  logic       out_valid_q;
  logic       in_acc;
  logic       out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Decode commands from state and counter
  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = in_acc;
    cmd_o.wave       = cnt_q[1:0];
    cmd_o.pt         = cnt_q[3:0];
    cmd_o.sq_sel     = cnt_q[1:0];
    cmd_o.sq_first   = (cnt_q == 6'd0);
    cmd_o.comp       = comp_q;
    unique case (state_q)
      ST_DECODE: cmd_o.clear_norm = 1'b1;
      ST_TICK:   cmd_o.tick_en    = 1'b1;
      ST_HGT:    cmd_o.pt_valid   = (cnt_q < 6'(NUM_PTS));
      ST_VEC:    cmd_o.vec_en     = 1'b1;
      ST_SQ:     cmd_o.sq_en      = 1'b1;
      ST_CHECK:  cmd_o.sqrt_load  = !sts_i.sq_zero;
      ST_SQRT:   cmd_o.sqrt_step  = 1'b1;
      ST_DIV: begin
        cmd_o.div_load  = (cnt_q == 6'd0);
        cmd_o.div_step  = (cnt_q != 6'd0) && (cnt_q <= 6'(DIV_STEPS));
        cmd_o.div_store = (cnt_q == 6'(DIV_STEPS + 1));
      end
      ST_FINISH: cmd_o.load_out   = out_free;
      default: ;
    endcase
  end

  // Hold state, counters and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_FINISH) && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_acc) state_q <= ST_DECODE;
        end
        ST_DECODE: begin
          cnt_q <= '0;
          if (sts_i.is_tick) state_q <= ST_TICK;
          else if (sts_i.bad) state_q <= ST_FINISH;
          else state_q <= ST_HGT;
        end
        ST_TICK: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) state_q <= ST_FINISH;
        end
        ST_HGT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(NUM_PTS)) state_q <= ST_VEC;
        end
        ST_VEC: begin
          cnt_q   <= '0;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd2) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          cnt_q   <= '0;
          comp_q  <= '0;
          state_q <= sts_i.sq_zero ? ST_FINISH : ST_SQRT;
        end
        ST_SQRT: begin
          if (cnt_q == 6'(SQRT_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_DIV: begin
          if (cnt_q == 6'(DIV_STEPS + 1)) begin
            cnt_q  <= '0;
            comp_q <= comp_q + 2'd1;
            if (comp_q == 2'd2) state_q <= ST_FINISH;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_FINISH: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A held result word is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result word overwritten while stalled");

  // An accepted request is decoded in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_DECODE))
    else $error("accepted request not decoded");

  // The root iteration stays within its step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (cnt_q < 6'(SQRT_STEPS)))
    else $error("square root overran");

  // Only one datapath phase is active at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.tick_en, cmd_o.pt_valid, cmd_o.sq_en, cmd_o.sqrt_step,
              cmd_o.div_step, cmd_o.load_out}))
    else $error("conflicting datapath commands");
`endif

endmodule

@@ hdl/wave_heightfield_normal_gen_unit.sv @@
// Top level of the wave heightfield normal generator.
//
//   channel | direction | handshake             | words
//   in      | input     | in_valid_i/in_stall_o | req_type, grid_x, grid_y, elapsed_time
//   out     | output    | out_valid_o/out_stall_i | height, normal_x..z, bad_index
//   cfg     | input     | cfg_we_i              | cfg_idx_i selects, cfg_wdata_i
//
// A vertex query runs from acceptance to result valid: nine heights through a
// two-stage table and scale pipeline, a 29-step square root and three divisions.
// A tick advances the four phases, one phase multiply a cycle; an out-of-range query goes straight to the result.
// One word is in flight; the input reopens in the cycle after the result loads, and the next
// word is taken while the last result waits in its register.
// Reset restores the register defaults and zero phases; the wave tables are constant.
`timescale 1ns / 1ps

module wave_heightfield_normal_gen_unit
  import whn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [7:0]         grid_x_i,
  input  logic [7:0]         grid_y_i,
  input  logic [15:0]        elapsed_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [18:0] height_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic               bad_index_o
);

  whn_cmd_t cmd;
  whn_sts_t sts;

  whn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  whn_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .grid_x_i       (grid_x_i),
    .grid_y_i       (grid_y_i),
    .elapsed_time_i (elapsed_time_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .height_o       (height_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .bad_index_o    (bad_index_o)
  );

endmodule

@@ sim/wave_heightfield_normal_gen_unit_tb.sv @@
// Self-checking testbench for the wave heightfield normal generator unit.
`timescale 1ns / 1ps

module wave_heightfield_normal_gen_unit_tb;
  import whn_pkg::*;

  localparam logic       REQ_QUERY   = 1'b0;
  localparam logic       REQ_TICK    = 1'b1;
  localparam logic [2:0] CFG_NONE    = 3'd6;
  localparam logic [63:0] PI_FIX     = 64'd3373259426;
  localparam int         CYCLE_LIMIT = 3000000;
  localparam int         DRAIN_WAIT  = 150;

  typedef enum logic [1:0] {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        req;
    logic [7:0]  gx;
    logic [7:0]  gy;
    logic [15:0] el;
    logic [2:0]  idx;
    logic [15:0] wdata;
    bit          typed;
    logic        typed_bad;
  } stim_row_t;

  typedef struct {
    logic signed [18:0] height;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               bad;
  } surf_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [15:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               req_type_i;
  logic [7:0]         grid_x_i;
  logic [7:0]         grid_y_i;
  logic [15:0]        elapsed_time_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [18:0] height_o;
  logic signed [15:0] normal_x_o;
  logic signed [15:0] normal_y_o;
  logic signed [15:0] normal_z_o;
  logic               bad_index_o;

  // Shadow state of the surface
  logic [8:0]         grid_reg;
  logic [15:0]        depth_reg;
  logic [15:0]        rate_reg [4];
  logic [23:0]        phase_reg [4];
  logic signed [15:0] wave_mem [4][256];

  surf_res_t surf_q[$];
  int        n_err;
  int        n_out;
  bit        busy_recv;
  bit        calm;
  longint    cyc;

  wave_heightfield_normal_gen_unit uut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  initial begin
    cyc = 0;
    wait (cyc >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic longint round_div(longint v, longint d);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q   = (mag + d / 2) / d;
    return (v < 0) ? -q : q;
  endfunction

  // Folded Taylor sine, Q30
  function automatic longint sin_fix(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    int          kk;
    int          quad;
    int          r;
    kk   = k & 255;
    quad = kk / 64;
    r    = kk % 64;
    if (quad % 2 == 1) r = 64 - r;
    x    = (64'(r) * PI_FIX) / 128;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    return (quad >= 2) ? -acc : acc;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint surf_height(int col, int row, int step);
    int     half;
    longint acc;
    half = step / 2;
    acc  = wave_mem[0][(int'(phase_reg[0][23:16]) + col * step - row * half) & 255];
    acc += wave_mem[1][(int'(phase_reg[1][23:16]) + col * half + row * step) & 255];
    acc += wave_mem[2][(int'(phase_reg[2][23:16]) + col * step) & 255];
    acc += wave_mem[3][(int'(phase_reg[3][23:16]) + row * step) & 255];
    return round_div(acc * longint'(depth_reg), 16384);
  endfunction

  function automatic logic signed [15:0] unit_comp(longint c, longint len);
    longint v;
    v = round_div(-c * 4194304, len);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return 16'(v);
  endfunction

  // Work out one result and advance the phases on a tick
  function automatic surf_res_t predict_surface(logic req, int gx, int gy, int el);
    surf_res_t   res;
    int          g;
    int          step;
    int          px;
    int          qx;
    int          py;
    int          qy;
    longint      f1;
    longint      f2;
    longint      f3;
    longint      f4;
    longint      vx;
    longint      vy;
    longint      vz;
    logic [63:0] sq;
    longint      len;
    res = '{default: 0};
    if (req == REQ_TICK) begin
      for (int i = 0; i < 4; i++)
        phase_reg[i] = 24'(phase_reg[i] + ((64'(rate_reg[i]) * 64'(el)) >> 8));
      return res;
    end
    g = int'(grid_reg);
    if (g < 2) g = 2;
    if (g > 256) g = 256;
    if (gx >= g || gy >= g) begin
      res.bad = 1'b1;
      return res;
    end
    step = 256 / (g - 1);
    px = (gx + g - 1) % g;
    qx = (gx + 1) % g;
    py = (gy + g - 1) % g;
    qy = (gy + 1) % g;
    res.height = 19'(surf_height(gx, gy, step));
    f1 = surf_height(qx, qy, step) - surf_height(px, py, step);
    f2 = surf_height(gx, qy, step) - surf_height(gx, py, step);
    f3 = surf_height(px, qy, step) - surf_height(qx, py, step);
    f4 = surf_height(qx, gy, step) - surf_height(px, gy, step);
    vx = f1 - f3 + f4;
    vz = f1 + f2 + f3;
    vy = -15 * longint'(depth_reg);
    sq = 64'(vx * vx) + 64'(vy * vy) + 64'(vz * vz);
    if (sq == 0) return res;
    len = longint'(int_sqrt(sq << 16));
    res.nx = unit_comp(vx, len);
    res.ny = unit_comp(vy, len);
    res.nz = unit_comp(vz, len);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
    n_err++;
  endtask

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls and one long hold-off
  initial begin
    int gap;
    out_stall_i = 1'b0;
    busy_recv   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (n_out == 40 && !busy_recv) begin
        busy_recv   = 1'b1;
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(negedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin
    surf_res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_out++;
      if (surf_q.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        w = surf_q.pop_front();
        if (height_o !== w.height) report_mismatch("height", height_o, w.height);
        if (normal_x_o !== w.nx) report_mismatch("normal_x", normal_x_o, w.nx);
        if (normal_y_o !== w.ny) report_mismatch("normal_y", normal_y_o, w.ny);
        if (normal_z_o !== w.nz) report_mismatch("normal_z", normal_z_o, w.nz);
        if (bad_index_o !== w.bad) report_mismatch("bad_index", bad_index_o, w.bad);
      end
    end
  end

  // Drop the input, hold until every expected word is out, then write one register
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    in_valid_i <= 1'b0;
    wait (surf_q.size() == 0);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_GRID_SIZE:  grid_reg  = val[8:0];
      CFG_DEPTH_GAIN: depth_reg = val;
      CFG_RATE0:      rate_reg[0] = val;
      CFG_RATE1:      rate_reg[1] = val;
      CFG_RATE2:      rate_reg[2] = val;
      CFG_RATE3:      rate_reg[3] = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one word and hold it until taken; typed rows carry their own expectation
  task automatic send_word(logic req, logic [7:0] gx, logic [7:0] gy, logic [15:0] el,
                           bit typed, logic typed_bad);
    surf_res_t exp_res;
    int        gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    grid_x_i       <= gx;
    grid_y_i       <= gy;
    elapsed_time_i <= el;
    do @(posedge clk_i); while (in_stall_o);
    exp_res = predict_surface(req, int'(gx), int'(gy), int'(el));
    if (typed) begin
      exp_res = '{default: 0};
      exp_res.bad = typed_bad;
    end
    surf_q.push_back(exp_res);
    @(negedge clk_i);
  endtask

  stim_row_t dir_rows[$];

  function automatic void add_word(logic req, int gx, int gy, int el, bit typed = 0,
                                   logic typed_bad = 0);
    stim_row_t r;
    r = '{kind: ROW_WORD, req: req, gx: 8'(gx), gy: 8'(gy), el: 16'(el), idx: 3'd0,
          wdata: 16'd0, typed: typed, typed_bad: typed_bad};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, int val);
    stim_row_t r;
    r = '{kind: ROW_CFG, req: 1'b0, gx: 8'd0, gy: 8'd0, el: 16'd0, idx: idx,
          wdata: 16'(val), typed: 0, typed_bad: 1'b0};
    dir_rows.push_back(r);
  endfunction

  initial begin
    int       g;
    int       r;
    int       gx;
    int       gy;
    logic [8:0] gsel;
    n_err = 0;
    n_out = 0;
    calm  = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; req_type_i = 1'b0; grid_x_i = '0; grid_y_i = '0;
    elapsed_time_i = '0;
    rst_ni = 1'b0;

    // Shadow reset state
    grid_reg  = 9'd33;
    depth_reg = 16'd4096;
    rate_reg  = '{16'd3187, 16'd3643, 16'd4280, 16'd5199};
    phase_reg = '{default: 0};
    for (int i = 0; i < 256; i++) begin
      wave_mem[0][i] = 16'(round_div(-9 * sin_fix(2 * i + 64), 655360));
      wave_mem[1][i] = 16'(round_div(-8 * sin_fix(4 * i + 64), 655360));
      wave_mem[2][i] = 16'(round_div(4 * sin_fix(3 * i), 655360));
      wave_mem[3][i] = 16'(round_div(-4 * sin_fix(8 * i + 64), 655360));
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: corners, ticks, bad indexes, grid and gain extremes
    add_word(REQ_QUERY, 0, 0, 0);
    add_word(REQ_QUERY, 32, 32, 16'hffff);
    add_word(REQ_QUERY, 33, 0, 0, 1, 1);
    add_word(REQ_QUERY, 0, 33, 0, 1, 1);
    add_word(REQ_QUERY, 255, 255, 0, 1, 1);
    add_word(REQ_TICK, 255, 255, 0, 1, 0);
    add_word(REQ_TICK, 0, 0, 16'hffff, 1, 0);
    add_word(REQ_QUERY, 5, 7, 0);
    add_cfg(CFG_GRID_SIZE, 0);
    add_word(REQ_QUERY, 1, 1, 0);
    add_word(REQ_QUERY, 2, 0, 0, 1, 1);
    add_cfg(CFG_GRID_SIZE, 1);
    add_word(REQ_QUERY, 0, 1, 0);
    add_cfg(CFG_GRID_SIZE, 511);
    add_word(REQ_QUERY, 255, 255, 0);
    add_word(REQ_QUERY, 0, 255, 0);
    add_cfg(CFG_DEPTH_GAIN, 0);
    add_word(REQ_QUERY, 128, 77, 0);
    add_cfg(CFG_DEPTH_GAIN, 16'hffff);
    add_cfg(CFG_RATE0, 16'hffff);
    add_cfg(CFG_RATE1, 0);
    add_cfg(CFG_RATE2, 16'hffff);
    add_cfg(CFG_RATE3, 1);
    add_cfg(CFG_NONE, 16'h1234);
    add_word(REQ_TICK, 0, 0, 16'hffff, 1, 0);
    add_word(REQ_QUERY, 170, 85, 0);
    add_cfg(CFG_GRID_SIZE, 256);
    add_word(REQ_QUERY, 255, 0, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      else send_word(dir_rows[i].req, dir_rows[i].gx, dir_rows[i].gy, dir_rows[i].el,
                     dir_rows[i].typed, dir_rows[i].typed_bad);
    end

    // Random phases, each with fresh settings
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      r = $urandom_range(0, 3);
      if (r == 0) gsel = 9'($urandom_range(0, 511));
      else if (r == 1) gsel = 9'(256);
      else gsel = 9'($urandom_range(2, 40));
      write_reg(CFG_GRID_SIZE, 16'(gsel));
      write_reg(CFG_DEPTH_GAIN, (ph == 5) ? 16'h0 : 16'($urandom_range(0, 65535)));
      write_reg(CFG_RATE0, 16'($urandom_range(0, 65535)));
      write_reg(CFG_RATE1, 16'($urandom_range(0, 65535)));
      write_reg(CFG_RATE2, 16'($urandom_range(0, 65535)));
      write_reg(CFG_RATE3, 16'($urandom_range(0, 65535)));
      g = int'(grid_reg);
      if (g < 2) g = 2;
      if (g > 256) g = 256;
      for (int k = 0; k < 125; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          send_word(REQ_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 0, 0);
        end else if (r < 22) begin
          send_word(REQ_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), 0, 0);
        end else begin
          gx = $urandom_range(0, g - 1);
          gy = $urandom_range(0, g - 1);
          send_word(REQ_QUERY, 8'(gx), 8'(gy), 16'($urandom), 0, 0);
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain
    wait (surf_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
